// ===== sv/wes_pkg.sv =====
// shared types and constants of the waveform envelope scanner
`timescale 1ns / 1ps
`default_nettype none
package wes_pkg;

  localparam logic [10:0] BUCKETS     = 11'd1000;
  localparam logic [15:0] MAX_SAMPLES = 16'd65535;
  localparam logic [14:0] LEVEL_CLAMP = 15'h7FFF;
  localparam logic [10:0] BC_MAX      = 11'h7FF;
  localparam logic [9:0]  IDX_MAX     = 10'h3FF;
  localparam int          SUM_W       = 32;
  localparam int          CNT_W       = 16;
  localparam int          QDEPTH      = 2;
  localparam int          QPTR_W      = $clog2(QDEPTH);
  localparam int          DIV_STEPS   = SUM_W;
  localparam int          DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [15:0] left_level;
    logic [15:0] right_level;
    logic [10:0] bucket_position;
    logic        finish;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  bucket_index;
    logic [14:0] average_level;
    logic        above_threshold;
    logic        fade_in_found;
    logic [9:0]  fade_in_bucket;
    logic [9:0]  fade_out_bucket;
    logic [14:0] overall_peak;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             finish;
    logic [9:0]       bucket;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [14:0]      peak;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== sv/wes_front.sv =====
// front end: accepts items, tracks peak and bucket sums, issues close and finish commands
`timescale 1ns / 1ps
`default_nettype none
module wes_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wes_pkg::in_item_t   in_item,
  input  wire wes_pkg::q_status_t  q_status,
  output logic                     push,
  output wes_pkg::cmd_t            push_data
);

  logic [10:0]                last_pos_r, last_pos_nxt;
  logic [10:0]                bc_r, bc_nxt;
  logic [wes_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [wes_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [14:0]                peak_r, peak_nxt;
  logic                       stopped_r, stopped_nxt;

  assign in_ready = !q_status.full;

  always_comb begin
    logic [15:0] mm;
    logic [14:0] lvl;
    logic [10:0] bc_inc;
    mm           = (in_item.left_level > in_item.right_level) ? in_item.left_level
                                                              : in_item.right_level;
    lvl          = mm[15] ? wes_pkg::LEVEL_CLAMP : mm[14:0];
    bc_inc       = (bc_r != wes_pkg::BC_MAX) ? bc_r + 11'd1 : bc_r;
    last_pos_nxt = last_pos_r;
    bc_nxt       = bc_r;
    sum_nxt      = sum_r;
    count_nxt    = count_r;
    peak_nxt     = peak_r;
    stopped_nxt  = stopped_r;
    push         = 1'b0;
    push_data    = '0;
    if (in_valid && in_ready && !stopped_r) begin
      if (in_item.finish) begin
        push             = 1'b1;
        push_data.finish = 1'b1;
        push_data.bucket = bc_r[10] ? wes_pkg::IDX_MAX : bc_r[9:0];
        push_data.peak   = peak_r;
        stopped_nxt      = 1'b1;
      end else if (last_pos_r < wes_pkg::BUCKETS) begin
        if (lvl > peak_r) begin
          peak_nxt = lvl;
        end
        if (count_r < wes_pkg::MAX_SAMPLES) begin
          sum_nxt   = sum_r + {{(wes_pkg::SUM_W-15){1'b0}}, lvl};
          count_nxt = count_r + 16'd1;
        end
        if (in_item.bucket_position > last_pos_r) begin
          bc_nxt = bc_inc;
          if (bc_inc < wes_pkg::BUCKETS) begin
            push             = 1'b1;
            push_data.bucket = bc_inc[9:0];
            push_data.sum    = sum_nxt;
            push_data.count  = count_nxt;
            push_data.peak   = peak_nxt;
            sum_nxt          = '0;
            count_nxt        = '0;
          end
          last_pos_nxt = in_item.bucket_position;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      bc_r       <= '0;
      sum_r      <= '0;
      count_r    <= '0;
      peak_r     <= '0;
      stopped_r  <= 1'b0;
    end else begin
      last_pos_r <= last_pos_nxt;
      bc_r       <= bc_nxt;
      sum_r      <= sum_nxt;
      count_r    <= count_nxt;
      peak_r     <= peak_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  a_stopped_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared");

endmodule
`default_nettype wire

// ===== sv/wes_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module wes_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire wes_pkg::cmd_t       push_data,
  input  wire logic                pop,
  output wes_pkg::cmd_t            pop_data,
  output wes_pkg::q_status_t       q_status
);

  wes_pkg::cmd_t                mem_r [wes_pkg::QDEPTH];
  logic [wes_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [wes_pkg::QPTR_W:0]     count_r;

  assign q_status.full  = (count_r == (wes_pkg::QPTR_W+1)'(wes_pkg::QDEPTH));
  assign q_status.empty = (count_r == '0);
  assign pop_data       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/wes_back.sv =====
// back end: bucket average divider, threshold marks and result register
`timescale 1ns / 1ps
`default_nettype none
module wes_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [14:0]         threshold,
  input  wire wes_pkg::q_status_t  q_status,
  input  wire wes_pkg::cmd_t       pop_data,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wes_pkg::out_item_t       out_item
);

  wes_pkg::back_state_t          state_r, state_nxt;
  wes_pkg::cmd_t                 cmd_r;
  logic [wes_pkg::CNT_W:0]       rem_r;
  logic [wes_pkg::SUM_W-1:0]     quo_r;
  logic [wes_pkg::DIV_CNT_W-1:0] step_r;
  logic                          found_r;
  logic [9:0]                    first_r, latest_r;
  wes_pkg::out_item_t            out_r;

  logic [wes_pkg::CNT_W:0]       shifted;
  logic                          ge;
  logic [wes_pkg::CNT_W:0]       rem_step;
  logic [wes_pkg::SUM_W-1:0]     quo_step;
  logic [14:0]                   avg;
  logic                          above;

  always_comb begin
    shifted  = {rem_r[wes_pkg::CNT_W-1:0], quo_r[wes_pkg::SUM_W-1]};
    ge       = (shifted >= {1'b0, cmd_r.count});
    rem_step = ge ? shifted - {1'b0, cmd_r.count} : shifted;
    quo_step = {quo_r[wes_pkg::SUM_W-2:0], ge};
    if (cmd_r.count == '0) begin
      avg = '0;
    end else if (quo_step[wes_pkg::SUM_W-1:15] != '0) begin
      avg = wes_pkg::LEVEL_CLAMP;
    end else begin
      avg = quo_step[14:0];
    end
    above = (avg > threshold);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wes_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = pop_data.finish ? wes_pkg::BK_DONE : wes_pkg::BK_DIV;
        end
      end
      wes_pkg::BK_DIV: begin
        if (step_r == wes_pkg::DIV_LAST) begin
          state_nxt = wes_pkg::BK_DONE;
        end
      end
      wes_pkg::BK_DONE: begin
        if (out_ready) begin
          state_nxt = wes_pkg::BK_IDLE;
        end
      end
      default: state_nxt = wes_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      wes_pkg::BK_IDLE: pop       = !q_status.empty;
      wes_pkg::BK_DIV:  pop       = 1'b0;
      wes_pkg::BK_DONE: out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wes_pkg::BK_IDLE;
      found_r  <= 1'b0;
      first_r  <= '0;
      latest_r <= '0;
      step_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == wes_pkg::BK_IDLE) begin
        step_r <= '0;
      end else if (state_r == wes_pkg::BK_DIV) begin
        step_r <= step_r + 1'b1;
        if (step_r == wes_pkg::DIV_LAST && above) begin
          if (!found_r) begin
            found_r <= 1'b1;
            first_r <= cmd_r.bucket;
          end
          latest_r <= cmd_r.bucket;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= pop_data;
      rem_r <= '0;
      quo_r <= pop_data.sum;
      if (pop_data.finish) begin
        out_r.bucket_index    <= pop_data.bucket;
        out_r.average_level   <= '0;
        out_r.above_threshold <= 1'b0;
        out_r.fade_in_found   <= found_r;
        out_r.fade_in_bucket  <= first_r;
        out_r.fade_out_bucket <= latest_r;
        out_r.overall_peak    <= pop_data.peak;
        out_r.last            <= 1'b1;
      end
    end else if (state_r == wes_pkg::BK_DIV) begin
      rem_r <= rem_step;
      quo_r <= quo_step;
      if (step_r == wes_pkg::DIV_LAST) begin
        out_r.bucket_index    <= cmd_r.bucket;
        out_r.average_level   <= avg;
        out_r.above_threshold <= above;
        out_r.fade_in_found   <= found_r | above;
        out_r.fade_in_bucket  <= (!found_r && above) ? cmd_r.bucket : first_r;
        out_r.fade_out_bucket <= above ? cmd_r.bucket : latest_r;
        out_r.overall_peak    <= cmd_r.peak;
        out_r.last            <= 1'b0;
      end
    end
  end

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.average_level == '0 && !out_item.above_threshold)
    else $error("summary item carries an average");

  a_fade_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.fade_in_found
      |-> out_item.fade_in_bucket == '0 && out_item.fade_out_bucket == '0)
    else $error("fade bucket set while none found");

  a_fade_latest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.above_threshold
      |-> out_item.fade_in_found && out_item.fade_out_bucket == out_item.bucket_index)
    else $error("audible bucket not marked latest");

endmodule
`default_nettype wire

// ===== sv/waveform_envelope_scanner.sv =====
// top level of the waveform envelope scanner
//
//   channel  ports                           moves
//   in       in_valid  in_ready  in_item     level pair, bucket position, finish
//   out      out_valid out_ready out_item    closed bucket or final summary
//   cfg      cfg_valid cfg_ready cfg_data    threshold level
//
// an ordinary item is taken by the front end alone; a bucket close adds a
// restoring divide, with a step each to start and hand off the result,
// in the back end, which holds one command while the two-entry queue buffers more
// in_ready drops only while the queue is full; the result register holds until taken
// synchronous active-low reset clears all counters, the peak, the marks and the queue
`timescale 1ns / 1ps
`default_nettype none
module waveform_envelope_scanner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire wes_pkg::in_item_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wes_pkg::out_item_t       out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [14:0]         cfg_data
);

  logic [14:0]         threshold_r;
  logic                push, pop;
  wes_pkg::cmd_t       push_data, pop_data;
  wes_pkg::q_status_t  q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold_r <= cfg_data;
    end
  end

  wes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  wes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  wes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
